// ===== rtl/core/lpd_pkg.sv =====
// Shared constants, codes and types of the looped pattern DAC sequencer.
// No dependencies; the modules of the block import this package.
package lpd_pkg;

    localparam int PATTERN_DEPTH  = 4096;
    localparam int PAT_AW         = $clog2(PATTERN_DEPTH);
    localparam int BUFFER_WORDS   = 64;
    localparam int BUF_W          = $clog2(BUFFER_WORDS);
    localparam int DAC_SHIFT_BITS = 8;

    localparam logic [31:0] CH0_COMMAND = 32'h0000_0000;
    localparam logic [31:0] CH1_COMMAND = 32'h0001_0000;

    localparam logic [PAT_AW-1:0] LOOP_END_RST   = PAT_AW'(1024 % PATTERN_DEPTH);
    localparam logic [12:0]       LOOP_LEN_RST   = 13'd1024;
    localparam logic [31:0]       GAIN_RST       = 32'h0001_0000;
    localparam logic [15:0]       LEVEL_RST      = 16'h8000;
    localparam logic [BUF_W-1:0]  BUF_LAST_POS   = BUF_W'(BUFFER_WORDS - 1);

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_LEVEL = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        AM_FIXED = 2'd0,
        AM_CH0   = 2'd1,
        AM_CH1   = 2'd2,
        AM_ALT   = 2'd3
    } t_amode;

    typedef enum logic [2:0] {
        CFG_ANALOG_MODE  = 3'd0,
        CFG_DIGITAL_MODE = 3'd1,
        CFG_GAIN0        = 3'd2,
        CFG_OFFSET0      = 3'd3,
        CFG_GAIN1        = 3'd4,
        CFG_OFFSET1      = 3'd5,
        CFG_LOOP_START   = 3'd6,
        CFG_LOOP_LENGTH  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        run;
        logic        use_fixed;
        logic        fix_ch;
        logic [15:0] level;
        logic        ch;
        logic        last;
    } t_s1;

    typedef struct packed {
        logic        digital_mode;
        logic [31:0] gain0;
        logic [31:0] offset0;
        logic [31:0] gain1;
        logic [31:0] offset1;
    } t_scale_cfg;

endpackage

// ===== rtl/core/lpd_in_if.sv =====
// Request channel of the looped pattern DAC sequencer: valid/ready plus fields.
// Stands alone; no package needed.
interface lpd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] address;
    logic [31:0] data;
    logic        run;
    logic [1:0]  update_mask;
    logic [15:0] level0;
    logic [15:0] level1;

    modport source (output valid, mode, address, data, run, update_mask, level0, level1,
                    input ready);
    modport sink   (input valid, mode, address, data, run, update_mask, level0, level1,
                    output ready);
endinterface

// ===== rtl/core/lpd_out_if.sv =====
// Result channel of the looped pattern DAC sequencer: valid/ready plus fields.
// Stands alone; no package needed.
interface lpd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] digital_bits;
    logic [31:0] dac_word;
    logic        buffer_last;

    modport source (output valid, digital_bits, dac_word, buffer_last, input ready);
    modport sink   (input valid, digital_bits, dac_word, buffer_last, output ready);
endinterface

// ===== rtl/core/lpd_scale.sv =====
// Scaling back end: gain multiply stage, offset/command add and output register.
// Depends on lpd_pkg and lpd_out_if.
module lpd_scale (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  lpd_pkg::t_s1            i_ctrl,
    input  logic [31:0]             i_word,
    input  lpd_pkg::t_scale_cfg     i_cfg,
    output logic                    o_ready,
    lpd_out_if.source               o_rsp
);
    import lpd_pkg::*;

    logic        r_v2;
    t_s1         r_s2;
    logic [31:0] r_prod;
    logic [15:0] r_dig2;
    logic        r_ov;
    logic [15:0] r_dig;
    logic [31:0] r_dac;
    logic        r_last;

    logic        w_rdy3;
    logic        w_rdy2;
    logic        w_move2;
    logic [31:0] w_gain;
    logic [31:0] w_prod;
    logic [15:0] w_dig;
    logic [31:0] w_value;
    logic [31:0] w_dac;

    assign w_rdy3  = !r_ov || o_rsp.ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;
    assign w_move2 = i_valid && w_rdy2;

    always_comb begin
        w_gain = i_ctrl.ch ? i_cfg.gain1 : i_cfg.gain0;
        w_prod = 32'({16'd0, i_word[15:0]} * w_gain);
        w_dig  = i_word[31:16];
        if (i_cfg.digital_mode) begin
            w_dig = w_dig | {8'd0, i_word[15:8]};
        end
        if (!i_ctrl.run) begin
            w_dig = 16'd0;
        end
    end

    always_comb begin
        if (r_s2.use_fixed) begin
            w_value = (r_s2.fix_ch ? CH1_COMMAND : CH0_COMMAND) + {16'd0, r_s2.level};
        end else begin
            w_value = {16'd0, r_prod[31:16]}
                    + (r_s2.ch ? i_cfg.offset1 : i_cfg.offset0)
                    + (r_s2.ch ? CH1_COMMAND : CH0_COMMAND);
        end
        w_dac = w_value << DAC_SHIFT_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_valid;
            end
            if (w_rdy3) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move2) begin
            r_s2   <= i_ctrl;
            r_prod <= w_prod;
            r_dig2 <= w_dig;
        end
        if (r_v2 && w_rdy3) begin
            r_dig  <= r_dig2;
            r_dac  <= w_dac;
            r_last <= r_s2.last;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.digital_bits = r_dig;
    assign o_rsp.dac_word     = r_dac;
    assign o_rsp.buffer_last  = r_last;

endmodule

// ===== rtl/core/looped_pattern_dac_sequencer.sv =====
// Looped pattern DAC sequencer: takes one request per clock (load, tick or level
// update) while i_req.ready is high; each tick yields one result, registered via r_s1, r_v2 and r_ov.
// The rate is set by the single pattern memory port, shared by loads and tick
// reads; a stalled result backs up through three stages before requests stop.
// The pattern memory is not cleared after reset; play only loaded words.
module looped_pattern_dac_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpd_in_if.sink      i_req,
    lpd_out_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import lpd_pkg::*;

    logic [31:0]       r_mem [PATTERN_DEPTH];
    logic [31:0]       r_rdata;

    t_amode            r_analog_mode;
    t_scale_cfg        r_scfg;
    logic [11:0]       r_loop_start;
    logic [12:0]       r_loop_length;

    logic [PAT_AW-1:0] r_play_index;
    logic [PAT_AW-1:0] r_loop_end;
    logic              r_run_latched;
    logic              r_run_prev;
    logic [BUF_W-1:0]  r_buf_pos;
    logic [1:0]        r_pending;
    logic [1:0]        r_override;
    logic [15:0]       r_level0;
    logic [15:0]       r_level1;

    logic              r_v1;
    t_s1               r_s1;

    logic              w_rdy1;
    logic              w_rdy2;
    logic              w_acc;
    logic              w_load;
    logic              w_tick;
    logic              w_level;
    logic              w_bp0;
    logic              w_bp1;
    logic [PAT_AW-1:0] w_start;
    logic [12:0]       w_sum;
    logic [PAT_AW-1:0] w_start_end;
    logic              w_restart;
    logic [PAT_AW-1:0] w_idx0;
    logic [PAT_AW-1:0] w_end0;
    logic [PAT_AW-1:0] w_idx1;
    logic              w_run;
    logic [1:0]        w_keep;
    logic [1:0]        w_ovr;
    logic              w_ovr0;
    logic              w_ovr1;
    t_s1               w_s1;

    assign w_rdy1       = !r_v1 || w_rdy2;
    assign i_req.ready  = w_rdy1;
    assign w_acc        = i_req.valid && w_rdy1;

    always_comb begin
        w_load  = 1'b0;
        w_tick  = 1'b0;
        w_level = 1'b0;
        case (i_req.mode)
            MODE_LOAD:  w_load  = w_acc;
            MODE_TICK:  w_tick  = w_acc;
            MODE_LEVEL: w_level = w_acc;
            default: ;
        endcase
    end

    always_comb begin
        w_bp0       = (r_buf_pos == '0);
        w_bp1       = (r_buf_pos == BUF_W'(1));
        w_start     = r_loop_start[PAT_AW-1:0];
        w_sum       = {1'b0, r_loop_start} + r_loop_length;
        w_start_end = w_sum[PAT_AW-1:0];
        w_restart   = w_bp0 && i_req.run && !r_run_prev;
        w_idx0      = w_restart ? w_start : r_play_index;
        w_end0      = w_restart ? w_start_end : r_loop_end;
        w_idx1      = w_idx0 + PAT_AW'(1);
        w_run       = w_bp0 ? i_req.run : r_run_latched;
        w_keep      = ~r_analog_mode;
        w_ovr       = w_bp0 ? (r_pending & w_keep) : r_override;
        w_ovr0      = w_bp0 && w_ovr[0];
        w_ovr1      = w_bp1 && w_ovr[1];

        w_s1.run       = w_run;
        w_s1.use_fixed = !w_run || (r_analog_mode == AM_FIXED) || w_ovr0 || w_ovr1;
        w_s1.fix_ch    = w_ovr1;
        w_s1.level     = w_ovr1 ? r_level1 : r_level0;
        w_s1.ch        = (r_analog_mode == AM_ALT) ? w_idx0[0] : (r_analog_mode == AM_CH1);
        w_s1.last      = (r_buf_pos == BUF_LAST_POS);
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[i_req.address[PAT_AW-1:0]] <= i_req.data;
        end
        if (w_tick) begin
            r_rdata <= r_mem[w_idx0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_analog_mode        <= AM_CH0;
            r_scfg.digital_mode  <= 1'b0;
            r_scfg.gain0         <= GAIN_RST;
            r_scfg.offset0       <= '0;
            r_scfg.gain1         <= GAIN_RST;
            r_scfg.offset1       <= '0;
            r_loop_start         <= '0;
            r_loop_length        <= LOOP_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ANALOG_MODE:  r_analog_mode       <= t_amode'(i_cfg_data[1:0]);
                CFG_DIGITAL_MODE: r_scfg.digital_mode <= i_cfg_data[0];
                CFG_GAIN0:        r_scfg.gain0        <= i_cfg_data;
                CFG_OFFSET0:      r_scfg.offset0      <= i_cfg_data;
                CFG_GAIN1:        r_scfg.gain1        <= i_cfg_data;
                CFG_OFFSET1:      r_scfg.offset1      <= i_cfg_data;
                CFG_LOOP_START:   r_loop_start        <= i_cfg_data[11:0];
                CFG_LOOP_LENGTH:  r_loop_length       <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_index  <= '0;
            r_loop_end    <= LOOP_END_RST;
            r_run_latched <= 1'b0;
            r_run_prev    <= 1'b0;
            r_buf_pos     <= '0;
            r_pending     <= '0;
            r_override    <= '0;
            r_level0      <= LEVEL_RST;
            r_level1      <= LEVEL_RST;
            r_v1          <= 1'b0;
        end else begin
            if (w_level) begin
                if (i_req.update_mask[0]) begin
                    r_level0 <= i_req.level0;
                end
                if (i_req.update_mask[1]) begin
                    r_level1 <= i_req.level1;
                end
                r_pending <= r_pending | i_req.update_mask;
            end
            if (w_tick) begin
                if (w_bp0) begin
                    r_run_prev    <= i_req.run;
                    r_run_latched <= i_req.run;
                    r_override    <= w_ovr;
                    r_pending     <= '0;
                end
                if (w_run && (w_idx1 == w_end0)) begin
                    r_play_index <= w_start;
                    r_loop_end   <= w_start_end;
                end else begin
                    r_play_index <= w_run ? w_idx1 : w_idx0;
                    r_loop_end   <= w_end0;
                end
                r_buf_pos <= (r_buf_pos == BUF_LAST_POS) ? '0 : r_buf_pos + BUF_W'(1);
            end
            if (w_rdy1) begin
                r_v1 <= w_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1 <= w_s1;
        end
    end

    lpd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_ctrl  (r_s1),
        .i_word  (r_rdata),
        .i_cfg   (r_scfg),
        .o_ready (w_rdy2),
        .o_rsp   (o_rsp)
    );

endmodule
